[rtl/mwm_pkg.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel mixer package
// Shared widths, constants and the item type passed from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwm_pkg;

   localparam int CMD_W    = 16;
   localparam int SPD_W    = 18;
   localparam int MAG_W    = 16;
   localparam int QUO_W    = 15;
   localparam int DUTY_W   = 12;
   localparam int DB_W     = 15;
   localparam int WHEELS   = 4;
   localparam int DIV_STEPS = QUO_W;

   localparam logic signed [CMD_W-1:0] ONE_Q14     = 16'sd16384;
   localparam logic signed [CMD_W-1:0] NEG_ONE_Q14 = -16'sd16384;
   localparam logic [MAG_W-1:0]        PEAK_FLOOR  = 16'd16384;
   localparam logic [DUTY_W-1:0]       DUTY_MAX    = 12'd4095;
   localparam logic [DB_W-1:0]         DB_RESET    = 15'd164;

   // Wheel order: front left, rear left, front right, rear right.
   typedef struct packed {
      logic [WHEELS-1:0]            neg;
      logic [WHEELS-1:0][MAG_W-1:0] mag;
      logic [MAG_W-1:0]             peak;
   } wheel_cmd_type;

endpackage

[rtl/mwm_front.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel mixer front end
// Saturates a command, mixes it into four wheel speeds and finds the peak.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [mwm_pkg::CMD_W-1:0]      req_forward_speed,
   input  logic signed [mwm_pkg::CMD_W-1:0]      req_lateral_speed,
   input  logic signed [mwm_pkg::CMD_W-1:0]      req_rotation_speed,
   output logic                                  fe_valid,
   input  logic                                  fe_take,
   output mwm_pkg::wheel_cmd_type                fe_cmd
);

   function automatic logic signed [mwm_pkg::SPD_W-1:0] sat_cmd(
      input logic signed [mwm_pkg::CMD_W-1:0] v);
      logic signed [mwm_pkg::CMD_W-1:0] s;
      begin
         s = v;
         if (v > mwm_pkg::ONE_Q14) s = mwm_pkg::ONE_Q14;
         if (v < mwm_pkg::NEG_ONE_Q14) s = mwm_pkg::NEG_ONE_Q14;
         sat_cmd = mwm_pkg::SPD_W'(s);
      end
   endfunction

   logic signed [mwm_pkg::SPD_W-1:0] vx, vy, wz;
   logic signed [mwm_pkg::SPD_W-1:0] spd [mwm_pkg::WHEELS];
   mwm_pkg::wheel_cmd_type cmd_in;
   mwm_pkg::wheel_cmd_type cmd_ff;
   logic valid_ff, valid_in;
   logic accept;

   // Mix into wheel speeds and take magnitudes and the floored peak.
   always_comb begin
      vx = sat_cmd(req_forward_speed);
      vy = sat_cmd(req_lateral_speed);
      wz = sat_cmd(req_rotation_speed);
      spd[0] = vx - vy - wz;
      spd[1] = vx + vy - wz;
      spd[2] = vx + vy + wz;
      spd[3] = vx - vy + wz;
      cmd_in.peak = mwm_pkg::PEAK_FLOOR;
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         cmd_in.neg[i] = spd[i][mwm_pkg::SPD_W-1];
         cmd_in.mag[i] = spd[i][mwm_pkg::SPD_W-1] ? mwm_pkg::MAG_W'(-spd[i])
                                                  : mwm_pkg::MAG_W'(spd[i]);
      end
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         if (cmd_in.mag[i] > cmd_in.peak) cmd_in.peak = cmd_in.mag[i];
      end
   end

   // One holding register; it frees up whenever the queue takes its item.
   assign req_stall = valid_ff && !fe_take;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !fe_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign fe_valid = valid_ff;
   assign fe_cmd   = cmd_ff;

endmodule

[rtl/mwm_queue.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel mixer queue
// Two-entry queue that decouples the front end from the divider pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_take,
   input  mwm_pkg::wheel_cmd_type push_cmd,
   output logic                   pop_valid,
   input  logic                   pop_take,
   output mwm_pkg::wheel_cmd_type pop_cmd
);

   mwm_pkg::wheel_cmd_type mem [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_take = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd   = mem[rd_ptr_ff];
   assign push      = push_valid && push_take;
   assign pop       = pop_valid && pop_take;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (pop && !push) count_in = count_ff - 2'd1;
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/mwm_back.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel mixer back end
// Pipelined restoring division by the peak, then duty and direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwm_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [mwm_pkg::DB_W-1:0]        deadband,
   input  logic                            in_valid,
   output logic                            in_take,
   input  mwm_pkg::wheel_cmd_type          in_cmd,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mwm_pkg::WHEELS-1:0][mwm_pkg::DUTY_W-1:0] fwd_duty,
   output logic [mwm_pkg::WHEELS-1:0][mwm_pkg::DUTY_W-1:0] rev_duty
);

   typedef struct packed {
      logic [mwm_pkg::WHEELS-1:0]                        neg;
      logic [mwm_pkg::WHEELS-1:0][mwm_pkg::MAG_W-1:0]    rem;
      logic [mwm_pkg::WHEELS-1:0][mwm_pkg::QUO_W-1:0]    quo;
      logic [mwm_pkg::MAG_W-1:0]                         den;
   } div_stage_type;

   div_stage_type st_ff  [mwm_pkg::DIV_STEPS];
   div_stage_type st_in  [mwm_pkg::DIV_STEPS];
   div_stage_type st_src [mwm_pkg::DIV_STEPS];
   logic [mwm_pkg::DIV_STEPS-1:0] vld_ff;
   logic          rsp_valid_ff;
   logic [mwm_pkg::WHEELS-1:0][mwm_pkg::DUTY_W-1:0] fwd_ff, rev_ff, fwd_in, rev_in;
   logic          adv;

   // The whole pipeline moves when the output slot is free or being taken.
   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign in_take = adv;

   // Each stage works on the item held by the stage before it; the first
   // stage starts from the incoming magnitudes with an empty quotient.
   always_comb begin
      st_src[0].neg = in_cmd.neg;
      st_src[0].rem = in_cmd.mag;
      st_src[0].quo = '0;
      st_src[0].den = in_cmd.peak;
      for (int k = 1; k < mwm_pkg::DIV_STEPS; k++) begin
         st_src[k] = st_ff[k-1];
      end
   end

   // One quotient bit per stage; the first stage tests the unshifted value.
   always_comb begin
      logic [mwm_pkg::MAG_W:0] trial;
      for (int k = 0; k < mwm_pkg::DIV_STEPS; k++) begin
         st_in[k].neg = st_src[k].neg;
         st_in[k].den = st_src[k].den;
         for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
            if (k == 0) begin
               trial = {1'b0, st_src[k].rem[i]};
            end else begin
               trial = {st_src[k].rem[i], 1'b0};
            end
            st_in[k].quo[i] = {st_src[k].quo[i][mwm_pkg::QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, st_src[k].den}) begin
               st_in[k].rem[i] = mwm_pkg::MAG_W'(trial - {1'b0, st_src[k].den});
               st_in[k].quo[i][0] = 1'b1;
            end else begin
               st_in[k].rem[i] = mwm_pkg::MAG_W'(trial);
            end
         end
      end
   end

   // Duty from the normalized magnitude, steered by sign and deadband.
   always_comb begin
      logic [mwm_pkg::QUO_W+11:0] prod;
      logic [mwm_pkg::DUTY_W:0]   duty;
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         prod = ({st_ff[mwm_pkg::DIV_STEPS-1].quo[i], 12'd0})
                - (mwm_pkg::QUO_W+12)'(st_ff[mwm_pkg::DIV_STEPS-1].quo[i]);
         duty = prod[mwm_pkg::QUO_W+11:14];
         if (duty > {1'b0, mwm_pkg::DUTY_MAX}) duty = {1'b0, mwm_pkg::DUTY_MAX};
         fwd_in[i] = '0;
         rev_in[i] = '0;
         if (st_ff[mwm_pkg::DIV_STEPS-1].quo[i] > deadband) begin
            if (st_ff[mwm_pkg::DIV_STEPS-1].neg[i]) rev_in[i] = duty[mwm_pkg::DUTY_W-1:0];
            else                                    fwd_in[i] = duty[mwm_pkg::DUTY_W-1:0];
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[mwm_pkg::DIV_STEPS-2:0], in_valid};
         rsp_valid_ff <= vld_ff[mwm_pkg::DIV_STEPS-1];
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < mwm_pkg::DIV_STEPS; k++) st_ff[k] <= st_in[k];
         fwd_ff <= fwd_in;
         rev_ff <= rev_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign fwd_duty  = fwd_ff;
   assign rev_duty  = rev_ff;

endmodule

[rtl/mecanum_wheel_mixer_top.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel mixer top level
// Velocity command in, eight forward/reverse PWM duties out.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel takes one command (forward, lateral, rotation, Q2.14)
// per item; the rsp_ channel returns one item with eight 12-bit duties.
// An item is moved when valid is high and stall is low at a clock edge.
// Mixing and peak search are registered at the accepting edge; the item then
// passes through the queue, the bit-per-stage divider and the duty output
// register. Throughput is one item per cycle while the receiver does not
// stall; the divider pipeline sets that figure. When the receiver stalls,
// the divider pipeline holds, the two-entry queue fills and then req_stall
// rises.
// Reset (synchronous, active high) empties all stages and the queue and
// sets the deadband to 164. csr_ writes take effect at once; the user must
// make them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mecanum_wheel_mixer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [mwm_pkg::DB_W-1:0]         csr_deadband_threshold,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [mwm_pkg::CMD_W-1:0] req_forward_speed,
   input  logic signed [mwm_pkg::CMD_W-1:0] req_lateral_speed,
   input  logic signed [mwm_pkg::CMD_W-1:0] req_rotation_speed,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mwm_pkg::DUTY_W-1:0]       rsp_front_left_fwd_duty,
   output logic [mwm_pkg::DUTY_W-1:0]       rsp_front_left_rev_duty,
   output logic [mwm_pkg::DUTY_W-1:0]       rsp_rear_left_fwd_duty,
   output logic [mwm_pkg::DUTY_W-1:0]       rsp_rear_left_rev_duty,
   output logic [mwm_pkg::DUTY_W-1:0]       rsp_front_right_fwd_duty,
   output logic [mwm_pkg::DUTY_W-1:0]       rsp_front_right_rev_duty,
   output logic [mwm_pkg::DUTY_W-1:0]       rsp_rear_right_fwd_duty,
   output logic [mwm_pkg::DUTY_W-1:0]       rsp_rear_right_rev_duty
);

   logic [mwm_pkg::DB_W-1:0] deadband_ff;
   logic fe_valid, fe_take, q_valid, q_take;
   mwm_pkg::wheel_cmd_type fe_cmd, q_cmd;
   logic [mwm_pkg::WHEELS-1:0][mwm_pkg::DUTY_W-1:0] fwd_duty, rev_duty;

   // Deadband register.
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= mwm_pkg::DB_RESET;
      end else if (csr_write) begin
         deadband_ff <= csr_deadband_threshold;
      end
   end

   mwm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_forward_speed  (req_forward_speed),
      .req_lateral_speed  (req_lateral_speed),
      .req_rotation_speed (req_rotation_speed),
      .fe_valid           (fe_valid),
      .fe_take            (fe_take),
      .fe_cmd             (fe_cmd)
   );

   mwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_take  (fe_take),
      .push_cmd   (fe_cmd),
      .pop_valid  (q_valid),
      .pop_take   (q_take),
      .pop_cmd    (q_cmd)
   );

   mwm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .deadband  (deadband_ff),
      .in_valid  (q_valid),
      .in_take   (q_take),
      .in_cmd    (q_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .fwd_duty  (fwd_duty),
      .rev_duty  (rev_duty)
   );

   // Wheel order inside: front left, rear left, front right, rear right.
   assign rsp_front_left_fwd_duty  = fwd_duty[0];
   assign rsp_front_left_rev_duty  = rev_duty[0];
   assign rsp_rear_left_fwd_duty   = fwd_duty[1];
   assign rsp_rear_left_rev_duty   = rev_duty[1];
   assign rsp_front_right_fwd_duty = fwd_duty[2];
   assign rsp_front_right_rev_duty = rev_duty[2];
   assign rsp_rear_right_fwd_duty  = fwd_duty[3];
   assign rsp_rear_right_rev_duty  = rev_duty[3];

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel mixer testbench
// Drives velocity commands through the mixer under random idling on both
// sides, predicts the eight wheel duties for every accepted item and checks
// each result in order. The deadband is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int PHASES       = 6;
   localparam int RAND_ITEMS   = 325;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic signed [mwm_pkg::CMD_W-1:0] fwd;
      logic signed [mwm_pkg::CMD_W-1:0] lat;
      logic signed [mwm_pkg::CMD_W-1:0] rot;
   } command_type;

   // Duties in port order: FL fwd/rev, RL fwd/rev, FR fwd/rev, RR fwd/rev.
   typedef logic [7:0][mwm_pkg::DUTY_W-1:0] duty_set_type;

   typedef struct packed {
      command_type  cmd;
      logic         known;
      duty_set_type duty;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [mwm_pkg::DB_W-1:0] csr_deadband_threshold = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [mwm_pkg::CMD_W-1:0] req_forward_speed = '0;
   logic signed [mwm_pkg::CMD_W-1:0] req_lateral_speed = '0;
   logic signed [mwm_pkg::CMD_W-1:0] req_rotation_speed = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   duty_set_type rsp_duty;

   logic [mwm_pkg::DB_W-1:0] deadband;
   duty_set_type    duty_queue [$];
   bit              rsp_idle_on = 1'b1;
   int              stall_left = 0;
   int              mismatches = 0;
   int              items_sent = 0;
   int              items_checked = 0;
   int              quiet_cycles = 0;

   always #2 clock = ~clock;

   mecanum_wheel_mixer_top i_dut (
      .clock                    (clock),
      .reset                    (reset),
      .csr_write                (csr_write),
      .csr_deadband_threshold   (csr_deadband_threshold),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_forward_speed        (req_forward_speed),
      .req_lateral_speed        (req_lateral_speed),
      .req_rotation_speed       (req_rotation_speed),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_front_left_fwd_duty  (rsp_duty[0]),
      .rsp_front_left_rev_duty  (rsp_duty[1]),
      .rsp_rear_left_fwd_duty   (rsp_duty[2]),
      .rsp_rear_left_rev_duty   (rsp_duty[3]),
      .rsp_front_right_fwd_duty (rsp_duty[4]),
      .rsp_front_right_rev_duty (rsp_duty[5]),
      .rsp_rear_right_fwd_duty  (rsp_duty[6]),
      .rsp_rear_right_rev_duty  (rsp_duty[7])
   );

   // Clamp a raw command to the range -1.0 .. +1.0.
   function automatic int clamp_command(logic signed [mwm_pkg::CMD_W-1:0] raw);
      int v;
      v = raw;
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v;
   endfunction

   // Mix a command into wheel speeds, normalize by the peak, apply deadband.
   function automatic duty_set_type wheel_duties(command_type cmd,
                                                 logic [mwm_pkg::DB_W-1:0] db);
      int vx, vy, wz, peak;
      int wheel [4];
      longint m, duty;
      duty_set_type d;
      vx = clamp_command(cmd.fwd);
      vy = clamp_command(cmd.lat);
      wz = clamp_command(cmd.rot);
      wheel[0] = vx - vy - wz;   // front left
      wheel[1] = vx + vy - wz;   // rear left
      wheel[2] = vx + vy + wz;   // front right
      wheel[3] = vx - vy + wz;   // rear right
      peak = 16384;
      for (int w = 0; w < 4; w++) begin
         if ((wheel[w] < 0 ? -wheel[w] : wheel[w]) > peak)
            peak = wheel[w] < 0 ? -wheel[w] : wheel[w];
      end
      d = '0;
      for (int w = 0; w < 4; w++) begin
         m = (longint'(wheel[w] < 0 ? -wheel[w] : wheel[w]) * 16384) / peak;
         duty = (m * 4095) >> 14;
         if (duty > 4095) duty = 4095;
         if (m > db) begin
            if (wheel[w] > 0) d[2*w] = duty[mwm_pkg::DUTY_W-1:0];
            else d[2*w+1] = duty[mwm_pkg::DUTY_W-1:0];
         end
      end
      return d;
   endfunction

   // Directed rows; a known row carries its expected duties, checked too.
   vector_type directed_rows [] = '{
      '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '0},
      '{'{16'sd16384, 16'sd0, 16'sd0}, 1'b1, {8{12'd4095}} & {4{12'd0, 12'd4095}}},
      '{'{-16'sd16384, 16'sd0, 16'sd0}, 1'b1, {4{12'd4095, 12'd0}}},
      '{'{16'sh7fff, 16'sd0, 16'sd0}, 1'b1, {4{12'd0, 12'd4095}}},
      '{'{16'sh8000, 16'sd0, 16'sd0}, 1'b1, {4{12'd4095, 12'd0}}},
      '{'{16'sd0, 16'sd16384, 16'sd0}, 1'b0, '0},
      '{'{16'sd0, 16'sd0, 16'sd16384}, 1'b0, '0},
      '{'{16'sd0, 16'sh7fff, 16'sh8000}, 1'b0, '0},
      '{'{16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
      '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
      '{'{16'sd164, 16'sd0, 16'sd0}, 1'b1, '0},
      '{'{16'sd165, 16'sd0, 16'sd0}, 1'b0, '0},
      '{'{-16'sd165, 16'sd0, 16'sd0}, 1'b0, '0},
      '{'{16'sd8192, 16'sd8192, 16'sd0}, 1'b0, '0},
      '{'{16'sd12000, -16'sd9000, 16'sd5000}, 1'b0, '0},
      '{'{16'sd1, -16'sd1, 16'sd1}, 1'b0, '0},
      '{'{16'shffff, 16'sh5555, 16'shaaaa}, 1'b0, '0},
      '{'{16'sd16385, -16'sd16385, 16'sd0}, 1'b0, '0}
   };

   // Idle bursts on the sending side, taken at random when enabled.
   task automatic sender_gap(bit enabled);
      int gap;
      if (enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Present one command and hold it until accepted.
   task automatic send_command(command_type cmd, bit idling);
      sender_gap(idling);
      req_valid <= 1'b1;
      req_forward_speed <= cmd.fwd;
      req_lateral_speed <= cmd.lat;
      req_rotation_speed <= cmd.rot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid after the last command and wait for all results.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (duty_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_deadband(logic [mwm_pkg::DB_W-1:0] value);
      csr_write <= 1'b1;
      csr_deadband_threshold <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      deadband = value;
   endtask

   // Random command: mostly in range, some full-scale raw values.
   function automatic logic signed [mwm_pkg::CMD_W-1:0] random_speed();
      case ($urandom_range(0, 9))
         0: return mwm_pkg::CMD_W'($urandom);
         1: return 16'sd16384;
         2: return -16'sd16384;
         3: return mwm_pkg::CMD_W'(int'($urandom_range(0, 400)) - 200);
         default: return mwm_pkg::CMD_W'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // Predict each accepted command at the edge where it moves.
   always @(posedge clock) begin
      command_type cmd;
      if (!reset && req_valid && !req_stall) begin
         cmd = '{req_forward_speed, req_lateral_speed, req_rotation_speed};
         duty_queue.push_back(wheel_duties(cmd, deadband));
      end
   end

   // Check each accepted result against the oldest prediction.
   always @(posedge clock) begin
      duty_set_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         items_checked++;
         if (duty_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Result with no command waiting");
         end else begin
            want = duty_queue.pop_front();
            for (int f = 0; f < 8; f++) begin
               if (rsp_duty[f] !== want[f]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Duty %0d: expected %0d, got %0d", f, want[f], rsp_duty[f]);
               end
            end
         end
      end
   end

   // Receiver stalls in random bursts unless switched off.
   always @(posedge clock) begin
      if (reset || !rsp_idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(1, 8);
      end
   end

   // Watchdog on cycles in which nothing moves.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (!reset) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results pending", duty_queue.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      logic [mwm_pkg::DB_W-1:0] db_list [PHASES];
      vector_type row;
      duty_set_type want;
      db_list = '{15'd0, 15'd16384, 15'd32767, 15'd1000, 15'd8191, 15'd40};
      deadband = mwm_pkg::DB_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at the reset deadband; known rows checked here too.
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.known) begin
            want = wheel_duties(row.cmd, deadband);
            if (want !== row.duty) begin
               mismatches++;
               if (mismatches <= 10) $display("Directed row %0d predicted wrongly", r);
            end
         end
         send_command(row.cmd, 1'b1);
      end
      drain_results();

      // Random phases, each at its own deadband; the last has no idling.
      for (int p = 0; p < PHASES; p++) begin
         write_deadband(db_list[p]);
         if (p == PHASES - 1) rsp_idle_on = 1'b0;
         for (int n = 0; n < RAND_ITEMS; n++)
            send_command('{random_speed(), random_speed(), random_speed()}, p != PHASES - 1);
         drain_results();
      end

      $display("Sent %0d commands over %0d deadband settings, checked %0d results.",
               items_sent, PHASES + 1, items_checked);
      if (mismatches == 0 && duty_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, duty_queue.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[mecanum_wheel_mixer_top.f]
rtl/mwm_pkg.sv
rtl/mwm_front.sv
rtl/mwm_queue.sv
rtl/mwm_back.sv
rtl/mecanum_wheel_mixer_top.sv
dv/testbench.sv
